[hdl/btl_pkg.sv]
// Shared types, constants and saturation helpers for the bitmap text layout block.
package btl_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int SCALE_SHIFT_DEF = 1;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic signed [5:0] KERNING_RESET = 6'sd2;

    typedef enum logic [3:0] {
        OP_NOP     = 4'b0001,
        OP_START   = 4'b0010,
        OP_NEWLINE = 4'b0100,
        OP_GLYPH   = 4'b1000
    } op_t;

    typedef struct packed {
        logic [11:0] sx;
        logic [11:0] sy;
        logic [7:0]  w;
        logic [7:0]  h;
    } glyph_t;

    typedef struct packed {
        op_t                op;
        glyph_t             glyph;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic               draw_enable;
    } entry_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [10:0] sat11(input logic signed [13:0] v);
        logic signed [10:0] r;
        if (v > 14'sd1023)
            r = 11'sh3ff;
        else if (v < -14'sd1024)
            r = 11'sh400;
        else
            r = v[10:0];
        return r;
    endfunction

endpackage

[hdl/btl_front.sv]
// Front end: accepts beats, owns the glyph table, classifies each beat for the back end.
module btl_front
    import btl_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [7:0]         code,
    input  logic [11:0]        src_x,
    input  logic [11:0]        src_y,
    input  logic [7:0]         glyph_w,
    input  logic [7:0]         glyph_h,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic               draw_enable,
    output logic               push_valid,
    output entry_t             push_entry,
    input  logic               push_ready
);

    localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    glyph_t                 mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0] glyph_valid_reg;
    logic [GLYPH_COUNT-1:0] glyph_valid_next;
    logic                   f_valid_reg;
    logic                   f_valid_next;

    logic [1:0]             f_kind_reg;
    logic [7:0]             f_code_reg;
    logic                   f_in_range_reg;
    logic signed [15:0]     f_origin_x_reg;
    logic signed [15:0]     f_origin_y_reg;
    logic                   f_draw_reg;
    glyph_t                 rd_glyph_reg;
    logic                   rd_valid_reg;

    logic                   accept;
    logic                   in_range;
    logic                   load_we;
    logic [IDX_W-1:0]       idx;
    glyph_t                 wr_glyph;

    assign in_stall   = f_valid_reg && !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = f_valid_reg;
    assign idx        = code[IDX_W-1:0];
    assign in_range   = {1'b0, code} < 9'(GLYPH_COUNT);
    assign load_we    = accept && (kind == KIND_LOAD) && in_range;
    assign wr_glyph   = '{sx: src_x, sy: src_y, w: glyph_w, h: glyph_h};

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
            f_valid_next = 1'b1;
        else if (push_ready)
            f_valid_next = 1'b0;
        glyph_valid_next = glyph_valid_reg;
        if (load_we)
            glyph_valid_next[idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg     <= 1'b0;
            glyph_valid_reg <= '0;
        end
        else
        begin
            f_valid_reg     <= f_valid_next;
            glyph_valid_reg <= glyph_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
            mem[idx] <= wr_glyph;
        if (accept)
        begin
            rd_glyph_reg   <= mem[idx];
            rd_valid_reg   <= glyph_valid_reg[idx];
            f_kind_reg     <= kind;
            f_code_reg     <= code;
            f_in_range_reg <= in_range;
            f_origin_x_reg <= origin_x;
            f_origin_y_reg <= origin_y;
            f_draw_reg     <= draw_enable;
        end
    end

    always_comb
    begin
        push_entry.glyph       = rd_glyph_reg;
        push_entry.origin_x    = f_origin_x_reg;
        push_entry.origin_y    = f_origin_y_reg;
        push_entry.draw_enable = f_draw_reg;
        case (f_kind_reg)
            KIND_START:
                push_entry.op = OP_START;
            KIND_CHAR:
            begin
                if (f_code_reg == NEWLINE_CODE)
                    push_entry.op = OP_NEWLINE;
                else if (f_in_range_reg && rd_valid_reg && (rd_glyph_reg.w != 8'd0))
                    push_entry.op = OP_GLYPH;
                else
                    push_entry.op = OP_NOP;
            end
            default:
                push_entry.op = OP_NOP;
        endcase
    end

endmodule

[hdl/btl_queue.sv]
// Short queue between the front and back ends.
module btl_queue
    import btl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  entry_t push_entry,
    output logic   push_ready,
    output logic   pop_valid,
    output entry_t pop_entry,
    input  logic   pop_take
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_take;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

[hdl/btl_back.sv]
// Back end: pen, extent and line state, quad generation and the result register.
module btl_back
    import btl_pkg::*;
#(
    parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata,
    input  logic               pop_valid,
    input  entry_t             pop_entry,
    output logic               pop_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               drawn,
    output logic signed [15:0] dest_x,
    output logic signed [15:0] dest_y,
    output logic signed [10:0] dest_w,
    output logic signed [10:0] dest_h,
    output logic [11:0]        out_src_x,
    output logic [11:0]        out_src_y,
    output logic [15:0]        bbox_w,
    output logic [15:0]        bbox_h
);

    logic signed [5:0]  kerning_reg;
    logic signed [15:0] origin_x_reg, origin_x_next;
    logic signed [15:0] origin_y_reg, origin_y_next;
    logic signed [15:0] pen_x_reg, pen_x_next;
    logic signed [15:0] pen_y_reg, pen_y_next;
    logic signed [15:0] ext_x_reg, ext_x_next;
    logic signed [15:0] ext_y_reg, ext_y_next;
    logic [7:0]         tallest_reg, tallest_next;
    logic               draw_mode_reg, draw_mode_next;
    logic               out_valid_reg, out_valid_next;

    logic               drawn_reg, drawn_next;
    logic signed [15:0] dest_x_reg, dest_x_next;
    logic signed [15:0] dest_y_reg, dest_y_next;
    logic signed [10:0] dest_w_reg, dest_w_next;
    logic signed [10:0] dest_h_reg, dest_h_next;
    logic [11:0]        src_x_reg, src_x_next;
    logic [11:0]        src_y_reg, src_y_next;
    logic [15:0]        bbox_w_reg, bbox_w_next;
    logic [15:0]        bbox_h_reg, bbox_h_next;

    logic signed [9:0]  kern10;
    logic signed [9:0]  wk;
    logic signed [9:0]  hk;
    logic signed [13:0] wk_scaled;
    logic signed [13:0] hk_scaled;
    logic [13:0]        w_scaled;
    logic [13:0]        h_scaled;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] adv_x;
    logic signed [15:0] nl_y;
    glyph_t             g;

    assign pop_take  = pop_valid && (!out_valid_reg || !out_stall);
    assign g         = pop_entry.glyph;

    assign kern10    = {{4{kerning_reg[5]}}, kerning_reg};
    assign wk        = $signed({2'b00, g.w}) + kern10;
    assign hk        = $signed({2'b00, g.h}) + kern10;
    assign wk_scaled = $signed({{4{wk[9]}}, wk}) <<< SCALE_SHIFT;
    assign hk_scaled = $signed({{4{hk[9]}}, hk}) <<< SCALE_SHIFT;
    assign w_scaled  = {6'd0, g.w} << SCALE_SHIFT;
    assign h_scaled  = {6'd0, g.h} << SCALE_SHIFT;
    assign cx        = sat16({{2{pen_x_reg[15]}}, pen_x_reg} + $signed({4'd0, w_scaled}));
    assign cy        = sat16({{2{pen_y_reg[15]}}, pen_y_reg} + $signed({4'd0, h_scaled}));
    assign adv_x     = sat16({{2{pen_x_reg[15]}}, pen_x_reg}
                             + {{4{wk_scaled[13]}}, wk_scaled});
    assign nl_y      = sat16({{2{origin_y_reg[15]}}, origin_y_reg}
                             + $signed({10'd0, tallest_reg}));

    always_comb
    begin
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        ext_x_next     = ext_x_reg;
        ext_y_next     = ext_y_reg;
        tallest_next   = tallest_reg;
        draw_mode_next = draw_mode_reg;
        drawn_next     = 1'b0;
        dest_x_next    = '0;
        dest_y_next    = '0;
        dest_w_next    = '0;
        dest_h_next    = '0;
        src_x_next     = '0;
        src_y_next     = '0;
        case (pop_entry.op)
            OP_START:
            begin
                origin_x_next  = pop_entry.origin_x;
                origin_y_next  = pop_entry.origin_y;
                pen_x_next     = pop_entry.origin_x;
                pen_y_next     = pop_entry.origin_y;
                ext_x_next     = pop_entry.origin_x;
                ext_y_next     = pop_entry.origin_y;
                tallest_next   = '0;
                draw_mode_next = pop_entry.draw_enable;
            end
            OP_NEWLINE:
            begin
                pen_x_next   = origin_x_reg;
                pen_y_next   = nl_y;
                tallest_next = '0;
            end
            OP_GLYPH:
            begin
                if (draw_mode_reg)
                begin
                    drawn_next  = 1'b1;
                    dest_x_next = pen_x_reg;
                    dest_y_next = pen_y_reg;
                    dest_w_next = sat11(wk_scaled);
                    dest_h_next = sat11(hk_scaled);
                    src_x_next  = g.sx;
                    src_y_next  = g.sy;
                end
                if (cx > ext_x_reg)
                    ext_x_next = cx;
                if (cy > ext_y_reg)
                    ext_y_next = cy;
                pen_x_next = adv_x;
                if (g.h > tallest_reg)
                    tallest_next = g.h;
            end
            default:
            begin
            end
        endcase
        bbox_w_next = 16'(ext_x_next - origin_x_next);
        bbox_h_next = 16'(ext_y_next - origin_y_next);

        out_valid_next = out_valid_reg;
        if (pop_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kerning_reg   <= KERNING_RESET;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            ext_x_reg     <= '0;
            ext_y_reg     <= '0;
            tallest_reg   <= '0;
            draw_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                kerning_reg <= cfg_wdata;
            out_valid_reg <= out_valid_next;
            if (pop_take)
            begin
                origin_x_reg  <= origin_x_next;
                origin_y_reg  <= origin_y_next;
                pen_x_reg     <= pen_x_next;
                pen_y_reg     <= pen_y_next;
                ext_x_reg     <= ext_x_next;
                ext_y_reg     <= ext_y_next;
                tallest_reg   <= tallest_next;
                draw_mode_reg <= draw_mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_take)
        begin
            drawn_reg  <= drawn_next;
            dest_x_reg <= dest_x_next;
            dest_y_reg <= dest_y_next;
            dest_w_reg <= dest_w_next;
            dest_h_reg <= dest_h_next;
            src_x_reg  <= src_x_next;
            src_y_reg  <= src_y_next;
            bbox_w_reg <= bbox_w_next;
            bbox_h_reg <= bbox_h_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drawn     = drawn_reg;
    assign dest_x    = dest_x_reg;
    assign dest_y    = dest_y_reg;
    assign dest_w    = dest_w_reg;
    assign dest_h    = dest_h_reg;
    assign out_src_x = src_x_reg;
    assign out_src_y = src_y_reg;
    assign bbox_w    = bbox_w_reg;
    assign bbox_h    = bbox_h_reg;

endmodule

[hdl/bitmap_text_layout_core.sv]
// Top level of the bitmap text layout block: front end, queue and back end.
// Path: a beat's result passes through the front register, a queue slot and the back-end result register.
// Throughput: one beat per cycle while in_stall is low; glyph table read in the front, pen update in the back.
// Reset: glyph table valid bits clear (all glyphs absent), origin, pen, extent zero,
// measure mode, kerning 2. No clearing pass; beats are taken right after reset.
module bitmap_text_layout_core
    import btl_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [7:0]         code,
    input  logic [11:0]        src_x,
    input  logic [11:0]        src_y,
    input  logic [7:0]         glyph_w,
    input  logic [7:0]         glyph_h,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic               draw_enable,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               drawn,
    output logic signed [15:0] dest_x,
    output logic signed [15:0] dest_y,
    output logic signed [10:0] dest_w,
    output logic signed [10:0] dest_h,
    output logic [11:0]        out_src_x,
    output logic [11:0]        out_src_y,
    output logic [15:0]        bbox_w,
    output logic [15:0]        bbox_h
);

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_take;
    entry_t pop_entry;

    btl_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .code        (code),
        .src_x       (src_x),
        .src_y       (src_y),
        .glyph_w     (glyph_w),
        .glyph_h     (glyph_h),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .draw_enable (draw_enable),
        .push_valid  (push_valid),
        .push_entry  (push_entry),
        .push_ready  (push_ready)
    );

    btl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_take   (pop_take)
    );

    btl_back #(
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_take  (pop_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drawn     (drawn),
        .dest_x    (dest_x),
        .dest_y    (dest_y),
        .dest_w    (dest_w),
        .dest_h    (dest_h),
        .out_src_x (out_src_x),
        .out_src_y (out_src_y),
        .bbox_w    (bbox_w),
        .bbox_h    (bbox_h)
    );

endmodule
